/* sv/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define AST_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sfls_pkg.sv */
// shared constants and codes for the sorted table first/last search unit
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package sfls_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int OP_W      = 2;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 3;
  localparam int IDX_W     = 11;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [ST_W-1:0] ST_CLEARED   = 3'd0;
  localparam logic [ST_W-1:0] ST_APPENDED  = 3'd1;
  localparam logic [ST_W-1:0] ST_DROPPED   = 3'd2;
  localparam logic [ST_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic [IDX_W-1:0] IDX_NONE = '1;

endpackage

/* sv/sorted_table_first_last_search_unit.sv */
// sorted table with first/last occurrence search by two binary searches
// depends on sfls_pkg; checked by sfls_checker (bound in its own file)
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------
// command   | start, busy          | op, value
// result    | done (1-cycle pulse) | status, first_index, last_index
//
// clear and append: result in the cycle after the beat, busy stays low.
// query: each search step is an address state, then a compare on the registered
//   memory read, up to log2(DEPTH)+1 steps for the lower bound and log2(DEPTH)
//   for the upper, with a check state between the two searches; busy for the
//   whole query, done as busy falls; the single memory port sets this pace.
// op 3 is taken and gives no result.
// rst clears the fill count, the state and done; table contents are undefined until written.
// the receiver cannot stall: done pulses for one cycle whatever happens.

module sorted_table_first_last_search_unit #(
  parameter int DEPTH = sfls_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [sfls_pkg::OP_W-1:0]           op,
  input  logic signed [sfls_pkg::VAL_W-1:0]   value,
  output logic                                done,
  output logic [sfls_pkg::ST_W-1:0]           status,
  output logic signed [sfls_pkg::IDX_W-1:0]   first_index,
  output logic signed [sfls_pkg::IDX_W-1:0]   last_index
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = sfls_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LB, S_LB_CMP, S_CHK, S_UB, S_UB_CMP
  } state_t;

  state_t state;

  logic [CW-1:0] fill;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [AW-1:0] first;
  logic signed [sfls_pkg::VAL_W-1:0] key;

  logic signed [sfls_pkg::VAL_W-1:0] mem [DEPTH];
  logic signed [sfls_pkg::VAL_W-1:0] rd_data;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;

  logic          full;
  logic [CW-1:0] mid_lb;
  logic [CW-1:0] mid_ub;
  logic [CW-1:0] span;
  logic [AW+IW-1:0] first_ext;
  logic [AW+IW-1:0] last_ext;

  assign busy   = (state != S_IDLE);
  assign full   = (fill == CW'(DEPTH));
  assign span   = hi - lo;
  assign mid_lb = lo + (span >> 1);
  assign mid_ub = lo + ((span + CW'(1)) >> 1);

  assign first_ext = {{IW{1'b0}}, first};
  assign last_ext  = {{IW{1'b0}}, lo[AW-1:0]};

  // one port: appends happen only when idle, probes only during a query
  always_comb begin
    mem_we   = (state == S_IDLE) && start && (op == sfls_pkg::OP_APPEND) && !full;
    mem_re   = 1'b0;
    mem_addr = fill[AW-1:0];
    case (state)
      S_LB: begin
        if (lo < hi) begin
          mem_re   = 1'b1;
          mem_addr = mid_lb[AW-1:0];
        end else if (lo < fill) begin
          mem_re   = 1'b1;
          mem_addr = lo[AW-1:0];
        end
      end
      S_UB: begin
        if (lo < hi) begin
          mem_re   = 1'b1;
          mem_addr = mid_ub[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= value;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (op)
              sfls_pkg::OP_CLEAR: begin
                fill        <= '0;
                done        <= 1'b1;
                status      <= sfls_pkg::ST_CLEARED;
                first_index <= sfls_pkg::IDX_NONE;
                last_index  <= sfls_pkg::IDX_NONE;
              end
              sfls_pkg::OP_APPEND: begin
                done        <= 1'b1;
                first_index <= sfls_pkg::IDX_NONE;
                last_index  <= sfls_pkg::IDX_NONE;
                if (full) begin
                  status <= sfls_pkg::ST_DROPPED;
                end else begin
                  status <= sfls_pkg::ST_APPENDED;
                  fill   <= fill + CW'(1);
                end
              end
              sfls_pkg::OP_QUERY: begin
                key   <= value;
                lo    <= '0;
                hi    <= fill;
                state <= S_LB;
              end
              default: begin
              end
            endcase
          end
        end
        // lower bound: first slot not below the key
        S_LB: begin
          if (lo < hi) begin
            mid   <= mid_lb;
            state <= S_LB_CMP;
          end else if (lo < fill) begin
            state <= S_CHK;
          end else begin
            done        <= 1'b1;
            status      <= sfls_pkg::ST_NOT_FOUND;
            first_index <= sfls_pkg::IDX_NONE;
            last_index  <= sfls_pkg::IDX_NONE;
            state       <= S_IDLE;
          end
        end
        S_LB_CMP: begin
          if (rd_data < key) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= S_LB;
        end
        S_CHK: begin
          if (rd_data != key) begin
            done        <= 1'b1;
            status      <= sfls_pkg::ST_NOT_FOUND;
            first_index <= sfls_pkg::IDX_NONE;
            last_index  <= sfls_pkg::IDX_NONE;
            state       <= S_IDLE;
          end else begin
            first <= lo[AW-1:0];
            hi    <= fill - CW'(1);
            state <= S_UB;
          end
        end
        // last slot not above the key, midpoint rounded up
        S_UB: begin
          if (lo < hi) begin
            mid   <= mid_ub;
            state <= S_UB_CMP;
          end else begin
            done        <= 1'b1;
            status      <= sfls_pkg::ST_FOUND;
            first_index <= $signed(first_ext[IW-1:0]);
            last_index  <= $signed(last_ext[IW-1:0]);
            state       <= S_IDLE;
          end
        end
        S_UB_CMP: begin
          if (rd_data > key) begin
            hi <= mid - CW'(1);
          end else begin
            lo <= mid;
          end
          state <= S_UB;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/sfls_checker.sv */
// port-level checks for the sorted table first/last search unit, with its bind
// depends on sfls_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfls_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [sfls_pkg::OP_W-1:0]           op,
  input logic                                done,
  input logic [sfls_pkg::ST_W-1:0]           status,
  input logic signed [sfls_pkg::IDX_W-1:0]   first_index,
  input logic signed [sfls_pkg::IDX_W-1:0]   last_index
);

  logic cmd_beat;
  assign cmd_beat = start && !busy;

  // a result beat always leaves the unit ready for the next command
  `AST_SAME(a_done_idle, clk, rst, done, !busy, "result beat while busy")

  // only a found query carries indices
  `AST_SAME(a_none_idx, clk, rst, done && (status != sfls_pkg::ST_FOUND),
    (first_index == sfls_pkg::IDX_NONE) && (last_index == sfls_pkg::IDX_NONE),
    "indices set on a result that is not a hit")

  `AST_NEXT(a_clear_next, clk, rst, cmd_beat && (op == sfls_pkg::OP_CLEAR),
    done && (status == sfls_pkg::ST_CLEARED), "clear did not answer next cycle")

  `AST_NEXT(a_query_busy, clk, rst, cmd_beat && (op == sfls_pkg::OP_QUERY),
    busy && !done, "query did not hold the unit busy")

  `AST_NEXT(a_append_next, clk, rst, cmd_beat && (op == sfls_pkg::OP_APPEND),
    done && ((status == sfls_pkg::ST_APPENDED) || (status == sfls_pkg::ST_DROPPED)),
    "append did not answer next cycle")

endmodule

bind sorted_table_first_last_search_unit sfls_checker u_sfls_checker (.*);
